>>> hdl/fhl_pkg.sv
package fhl_pkg;

    localparam int DATA_W  = 8;
    localparam int CFG_W   = 16;
    localparam int LEN_W   = 32;
    localparam int CNT_W   = 10;
    localparam int START_W = 9;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = 33;
    localparam int OUT_W   = 56;

    localparam logic [DATA_W-1:0] CH_S   = 8'h53;
    localparam logic [DATA_W-1:0] CH_D   = 8'h44;
    localparam logic [DATA_W-1:0] CH_END = 8'hFF;

    localparam logic [CFG_W-1:0] MIN_HDR   = 16'd12;
    localparam logic [CFG_W-1:0] MIN_RESET = 16'd17;
    localparam logic [CFG_W-1:0] MAX_RESET = 16'd512;

    localparam int SCAN_START = 8;
    localparam int HDR_BACK   = 8;
    localparam int LEN_BACK   = 4;
    localparam int D_AHEAD    = 3;
    localparam int TAIL_KEEP  = 7;

    localparam logic REG_MIN_FRAME_LEN = 1'b0;
    localparam logic REG_MAX_FRAME_LEN = 1'b1;

    localparam logic [STAT_W-1:0] STAT_WAIT     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DISCARD  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FRAME    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_LEN_RD,
        ST_LEN_CAP,
        ST_CHECK,
        ST_CHK_D,
        ST_CHK_END,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        KIND_SHORT,
        KIND_OVF,
        KIND_NOMARK,
        KIND_BAD,
        KIND_INCOMPLETE,
        KIND_BADEND,
        KIND_FRAME
    } kind_t;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_LEN,
        RD_D,
        RD_END
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    scan;
        logic    len_cap;
        logic    set_kind;
        kind_t   kind;
        rd_sel_t rd_sel;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last_ovf;
        logic last_short;
        logic hit;
        logic exhausted;
        logic idx_last;
        logic bounds_bad;
        logic incomplete;
        logic d_ok;
        logic end_ok;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> hdl/fhl_ctrl.sv
module fhl_ctrl
    import fhl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.scan     = 1'b0;
        cmd.len_cap  = 1'b0;
        cmd.set_kind = 1'b0;
        cmd.kind     = KIND_SHORT;
        cmd.rd_sel   = RD_SCAN;
        cmd.emit     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    if (stat.last_ovf) begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = KIND_OVF;
                        state_next   = ST_EMIT;
                    end else if (stat.last_short) begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = KIND_SHORT;
                        state_next   = ST_EMIT;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                cmd.scan   = 1'b1;
                cmd.rd_sel = RD_SCAN;
                if (stat.hit) begin
                    state_next = ST_LEN_RD;
                end else if (stat.exhausted) begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = KIND_NOMARK;
                    state_next   = ST_EMIT;
                end
            end
            ST_LEN_RD: begin
                cmd.rd_sel = RD_LEN;
                state_next = ST_LEN_CAP;
            end
            ST_LEN_CAP: begin
                cmd.len_cap = 1'b1;
                state_next  = stat.idx_last ? ST_CHECK : ST_LEN_RD;
            end
            ST_CHECK: begin
                cmd.rd_sel = RD_D;
                if (stat.bounds_bad) begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = KIND_BAD;
                    state_next   = ST_EMIT;
                end else if (stat.incomplete) begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = KIND_INCOMPLETE;
                    state_next   = ST_EMIT;
                end else begin
                    state_next = ST_CHK_D;
                end
            end
            ST_CHK_D: begin
                cmd.rd_sel = RD_END;
                if (!stat.d_ok) begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = KIND_BAD;
                    state_next   = ST_EMIT;
                end else begin
                    state_next = ST_CHK_END;
                end
            end
            ST_CHK_END: begin
                cmd.set_kind = 1'b1;
                cmd.kind     = stat.end_ok ? KIND_FRAME : KIND_BADEND;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> hdl/fhl_dp.sv
module fhl_dp
    import fhl_pkg::*;
#(
    parameter int BUF_DEPTH = 512
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int FW = $clog2(BUF_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUF_DEPTH);

    logic [DATA_W-1:0] mem [BUF_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;

    logic [CFG_W-1:0] min_len_reg, max_len_reg;
    logic [FW-1:0]    fill_reg, n_reg, scan_reg, pend_addr_reg, s_reg;
    logic             ovf_reg, pend_reg;
    logic [1:0]       idx_reg;
    logic [LEN_W-1:0] len_reg;
    kind_t            kind_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [START_W-1:0] out_start_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic [CFG_W-1:0] mn;
    logic [FW-1:0]    start, room;
    logic [CMP_W-1:0] len_x;
    logic             full;

    assign mn    = (min_len_reg < MIN_HDR) ? MIN_HDR : min_len_reg;
    assign full  = (fill_reg == DEPTH_F);
    assign start = s_reg - FW'(HDR_BACK);
    assign room  = n_reg - start;
    assign len_x = {len_reg[LEN_W-1], len_reg};

    always_comb begin
        case (cmd.rd_sel)
            RD_SCAN: rd_addr = scan_reg[AW-1:0];
            RD_LEN:  rd_addr = AW'(s_reg - FW'(LEN_BACK) + FW'(idx_reg));
            RD_D:    rd_addr = AW'(s_reg + FW'(D_AHEAD));
            RD_END:  rd_addr = AW'(start + len_reg[FW-1:0] - FW'(1));
            default: rd_addr = scan_reg[AW-1:0];
        endcase
    end

    always_comb begin
        stat.last_ovf   = ovf_reg || full;
        stat.last_short = CMP_W'(fill_reg + FW'(1)) < CMP_W'(mn);
        stat.hit        = pend_reg && (rd_data_reg == CH_S);
        stat.exhausted  = !pend_reg && (scan_reg >= n_reg);
        stat.idx_last   = (idx_reg == 2'd3);
        stat.bounds_bad = ($signed(len_x) > $signed(CMP_W'(max_len_reg)))
                       || ($signed(len_x) < $signed(CMP_W'(mn)));
        stat.incomplete = $signed(len_x) > $signed(CMP_W'(room));
        stat.d_ok       = (rd_data_reg == CH_D);
        stat.end_ok     = (rd_data_reg == CH_END);
        stat.out_busy   = out_valid_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && !full) begin
            mem[fill_reg[AW-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= MIN_RESET;
            max_len_reg <= MAX_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_FRAME_LEN: min_len_reg <= cfg_data;
                REG_MAX_FRAME_LEN: max_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (s_tlast) begin
                    fill_reg <= '0;
                    ovf_reg  <= 1'b0;
                    pend_reg <= 1'b0;
                end else if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            if (cmd.scan) begin
                if (stat.hit) begin
                    pend_reg <= 1'b0;
                end else begin
                    pend_reg <= (scan_reg < n_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_tlast) begin
            n_reg    <= fill_reg + FW'(1);
            scan_reg <= FW'(SCAN_START);
        end
        if (cmd.scan) begin
            if (stat.hit) begin
                s_reg   <= pend_addr_reg;
                idx_reg <= 2'd0;
            end else if (scan_reg < n_reg) begin
                pend_addr_reg <= scan_reg;
                scan_reg      <= scan_reg + FW'(1);
            end
        end
        if (cmd.len_cap) begin
            len_reg[idx_reg*DATA_W +: DATA_W] <= rd_data_reg;
            idx_reg <= idx_reg + 2'd1;
        end
        if (cmd.set_kind) begin
            kind_reg <= cmd.kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_stat_reg  <= STAT_WAIT;
            out_cnt_reg   <= '0;
            out_start_reg <= START_W'(start);
            out_len_reg   <= len_reg;
            case (kind_reg)
                KIND_SHORT: begin
                    out_start_reg <= '0;
                    out_len_reg   <= '0;
                end
                KIND_OVF: begin
                    out_stat_reg  <= STAT_OVERFLOW;
                    out_start_reg <= '0;
                    out_len_reg   <= '0;
                end
                KIND_NOMARK: begin
                    out_stat_reg  <= STAT_DISCARD;
                    out_cnt_reg   <= CNT_W'(n_reg - FW'(TAIL_KEEP));
                    out_start_reg <= '0;
                    out_len_reg   <= '0;
                end
                KIND_BAD: begin
                    out_stat_reg <= STAT_DISCARD;
                    out_cnt_reg  <= CNT_W'(1);
                end
                KIND_INCOMPLETE: begin
                    out_stat_reg <= STAT_WAIT;
                end
                KIND_BADEND: begin
                    out_stat_reg <= STAT_DISCARD;
                    out_cnt_reg  <= CNT_W'(start) + CNT_W'(1);
                end
                KIND_FRAME: begin
                    out_stat_reg <= STAT_FRAME;
                    out_cnt_reg  <= CNT_W'(start) + len_reg[CNT_W-1:0];
                end
                default: begin
                    out_stat_reg <= STAT_WAIT;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_start_reg, out_cnt_reg, out_stat_reg};

endmodule

>>> hdl/frame_header_locator.sv
// Receive-buffer frame locator. Bytes enter one per beat on the s_ channel and
// fill an internal buffer of BUF_DEPTH bytes; the beat with s_tlast ends the buffer
// and triggers one result beat on the m_ channel (wait, discard n bytes, frame
// found, or overflow). Loading runs at one byte per cycle. After the last byte
// the block stops accepting while it parses: it walks the buffer from offset 8
// for 'S' through the single buffer read port at one byte per cycle (the
// dominant cost), then reads the length field, the 'D' byte and the end byte
// one at a time, and then posts the result. A short or overflowed buffer is
// answered without a search. Configuration writes (index 0 min_frame_len,
// index 1 max_frame_len) are always accepted and must be issued while idle.
module frame_header_locator
    import fhl_pkg::*;
#(
    parameter int BUF_DEPTH = 512
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [1:0] status, [11:2] byte_count,
                                         // [20:12] frame_start, [52:21] frame_len
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    fhl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fhl_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
